// File: sv/greedy_hamming_code_builder_assert.svh
// ----------------------------------------------------------------------------
// greedy hamming code builder assertion macros
// concurrent check helpers, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef GREEDY_HAMMING_CODE_BUILDER_ASSERT_SVH
`define GREEDY_HAMMING_CODE_BUILDER_ASSERT_SVH

// same-cycle implication
`define GCB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// shared constants, types and helpers of the greedy hamming code builder
// ----------------------------------------------------------------------------
`default_nettype none

package gcb_pkg;

  localparam int unsigned VECTOR_BITS = 16;
  localparam int unsigned MAX_WORDS   = 1024;
  localparam int unsigned ADDR_W      = $clog2(MAX_WORDS);
  localparam int unsigned CNT_W       = $clog2(MAX_WORDS + 1);
  localparam int unsigned DIST_W      = $clog2(VECTOR_BITS + 1);
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned WC_W        = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] VECTOR_LENGTH_RST = 5'd8;
  localparam logic [CFG_W-1:0] MIN_DISTANCE_RST  = 5'd3;

  // commands
  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // operands of one distance check
  typedef struct packed {
    logic [VECTOR_BITS-1:0] word;
    logic [VECTOR_BITS-1:0] mask;
    logic [CFG_W-1:0]       need;
  } gcb_cmp_t;

  // mask of the compared bits, length held to 1..VECTOR_BITS
  function automatic logic [VECTOR_BITS-1:0] eff_mask(input logic [CFG_W-1:0] vlen);
    int unsigned len;
    logic [VECTOR_BITS-1:0] m;
    len = 32'(vlen);
    if (len < 1) len = 1;
    if (len > VECTOR_BITS) len = VECTOR_BITS;
    for (int unsigned b = 0; b < VECTOR_BITS; b++) begin
      m[b] = (b < len);
    end
    return m;
  endfunction

  // minimum distance held at one or more
  function automatic logic [CFG_W-1:0] eff_need(input logic [CFG_W-1:0] mdist);
    return (mdist == '0) ? CFG_W'(1) : mdist;
  endfunction

endpackage

`default_nettype wire

// File: sv/gcb_dist_check.sv
// ----------------------------------------------------------------------------
// gcb_dist_check
// hamming distance of a candidate to one stored codeword, against the minimum
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_dist_check (
  input  gcb_pkg::gcb_cmp_t                 cmp_i,
  input  logic [gcb_pkg::VECTOR_BITS-1:0]   codeword_i,
  output logic                              too_close_o
);
  import gcb_pkg::*;

  logic [VECTOR_BITS-1:0] diff;
  logic [DIST_W-1:0]      ham_dist;

  assign diff     = (cmp_i.word ^ codeword_i) & cmp_i.mask;
  assign ham_dist = DIST_W'($countones(diff));

  // distance below the required minimum
  assign too_close_o = (32'(ham_dist) < 32'(cmp_i.need));

endmodule

`default_nettype wire

// File: sv/greedy_hamming_code_builder.sv
// ----------------------------------------------------------------------------
// greedy_hamming_code_builder
// greedy code (lexicode) builder over a store of codewords in block memory
// ----------------------------------------------------------------------------
// A test beat (cmd 0) compares its candidate, cut to vector_length low bits,
// with every stored codeword in order; it is added when each distance reaches
// min_distance and there is room, otherwise refused (store_full marks a
// refusal for lack of room only). A clear beat (cmd 1) empties the store. A
// test beat reads the stored words through the single read port of the
// codeword memory, which hands out one stored word per cycle, and a close
// codeword ends the scan early. One beat is worked on at a time, and the
// next is taken as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_hamming_code_builder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [gcb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gcb_pkg::CFG_W-1:0]          cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [gcb_pkg::VECTOR_BITS-1:0]    candidate_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               accepted_o,
  output logic [gcb_pkg::WC_W-1:0]           word_count_o,
  output logic                               store_full_o
);
  import gcb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } gcb_state_e;

  gcb_state_e state_q, state_d;

  // configuration registers
  logic [CFG_W-1:0] vlen_q, mdist_q;

  // candidate held for the scan
  gcb_cmp_t cmp_q;

  // store bookkeeping and scan pointer
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;

  // result waiting for the output register
  logic res_acc_q, res_acc_d;
  logic res_full_q, res_full_d;

  // output register
  logic            out_valid_q;
  logic            out_acc_q;
  logic [WC_W-1:0] out_wc_q;
  logic            out_full_q;

  // codeword memory, one read and one write port
  logic [VECTOR_BITS-1:0] mem [MAX_WORDS];
  logic [VECTOR_BITS-1:0] rdata_q;
  logic                   mem_we;

  logic in_fire, out_free, issue, too_close;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = (state_q == ST_SCAN) && (idx_q != count_q);

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign word_count_o = out_wc_q;
  assign store_full_o = out_full_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q  <= VECTOR_LENGTH_RST;
      mdist_q <= MIN_DISTANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VECTOR_LENGTH: vlen_q  <= cfg_data_i;
        REG_MIN_DISTANCE:  mdist_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // distance check against the word read last cycle
  gcb_dist_check u_dist (
    .cmp_i       (cmp_q),
    .codeword_i  (rdata_q),
    .too_close_o (too_close)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    res_acc_d  = res_acc_q;
    res_full_d = res_full_q;
    mem_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_i == CMD_CLEAR) begin
            count_d    = '0;
            res_acc_d  = 1'b0;
            res_full_d = 1'b0;
            state_d    = ST_FINISH;
          end else begin
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, checked when its data returns
        if (issue) idx_d = idx_q + CNT_W'(1);
        pend_d = issue;
        if (pend_q && too_close) begin
          pend_d     = 1'b0;
          res_acc_d  = 1'b0;
          res_full_d = 1'b0;
          state_d    = ST_FINISH;
        end else if (!issue && !pend_q) begin
          // every stored word far enough away
          if (count_q < CNT_W'(MAX_WORDS)) begin
            mem_we     = 1'b1;
            count_d    = count_q + CNT_W'(1);
            res_acc_d  = 1'b1;
            res_full_d = 1'b0;
          end else begin
            res_acc_d  = 1'b0;
            res_full_d = 1'b1;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      res_acc_q  <= 1'b0;
      res_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
      res_acc_q  <= res_acc_d;
      res_full_q <= res_full_d;
    end
  end

  // candidate capture, masked to the compared bits
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmp_q.mask <= eff_mask(vlen_q);
      cmp_q.word <= candidate_i & eff_mask(vlen_q);
      cmp_q.need <= eff_need(mdist_q);
    end
  end

  // memory ports; a write only follows a finished scan, so reads never race it
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[ADDR_W-1:0]] <= cmp_q.word;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[idx_q[ADDR_W-1:0]];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      out_acc_q  <= res_acc_q;
      out_wc_q   <= WC_W'(count_q);
      out_full_q <= res_full_q;
    end
  end

  // checks
  `include "greedy_hamming_code_builder_assert.svh"

  `GCB_ASSERT_IMPL(a_write_has_room, mem_we, count_q < CNT_W'(MAX_WORDS), "write into full store")
  `GCB_ASSERT_NEXT(a_clear_empties, in_fire && (cmd_i == CMD_CLEAR), count_q == '0, "clear left words")
  `GCB_ASSERT_IMPL(a_acc_not_full, out_valid_o && accepted_o, !store_full_o && (word_count_o != '0), "bad result")

endmodule

`default_nettype wire

// File: test/gcb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_checker
// watches both channels and the register port of the code builder, works out
// the verdict on each candidate beat and compares it with the result beat
// ----------------------------------------------------------------------------

module gcb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gcb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gcb_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            cmd_i,
  input  logic [gcb_pkg::VECTOR_BITS-1:0] candidate_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            accepted_i,
  input  logic [gcb_pkg::WC_W-1:0]        word_count_i,
  input  logic                            store_full_i,
  output int                              fail_count_o,
  output int                              outstanding_o
);

  import gcb_pkg::*;

  typedef struct packed {
    logic            accepted;
    logic [WC_W-1:0] word_count;
    logic            store_full;
  } gcb_verdict_t;

  logic [VECTOR_BITS-1:0] codewords [MAX_WORDS];
  int unsigned            word_total;
  logic [CFG_W-1:0]       vec_len_q;
  logic [CFG_W-1:0]       min_dist_q;
  gcb_verdict_t           pending_verdicts [$];
  gcb_verdict_t           verdict;
  int                     fails;

  // verdict on one beat, updates the local codeword store
  task automatic judge_candidate(input logic cmd, input logic [VECTOR_BITS-1:0] cand,
                                 output gcb_verdict_t v);
    int unsigned            len;
    int unsigned            need;
    logic [VECTOR_BITS-1:0] mask;
    logic [VECTOR_BITS-1:0] word;
    bit                     fits;
    v = '0;
    if (cmd == CMD_CLEAR) begin
      word_total = 0;
    end else begin
      len = vec_len_q;
      if (len < 1) len = 1;
      if (len > VECTOR_BITS) len = VECTOR_BITS;
      mask = '0;
      for (int b = 0; b < len; b++) mask[b] = 1'b1;
      word = cand & mask;
      need = (min_dist_q == '0) ? 1 : min_dist_q;
      fits = 1'b1;
      for (int i = 0; i < word_total && fits; i++) begin
        if ($countones((word ^ codewords[i]) & mask) < need) fits = 1'b0;
      end
      if (fits) begin
        if (word_total >= MAX_WORDS) begin
          v.store_full = 1'b1;
        end else begin
          codewords[word_total] = word;
          word_total++;
          v.accepted = 1'b1;
        end
      end
    end
    v.word_count = WC_W'(word_total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_total = 0;
      vec_len_q  = VECTOR_LENGTH_RST;
      min_dist_q = MIN_DISTANCE_RST;
      pending_verdicts.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          $error("result beat with no candidate waiting");
          fails++;
        end else begin
          verdict = pending_verdicts.pop_front();
          if (accepted_i !== verdict.accepted) begin
            $error("accepted: expected %0d, actual %0d", verdict.accepted, accepted_i);
            fails++;
          end
          if (word_count_i !== verdict.word_count) begin
            $error("word_count: expected %0d, actual %0d", verdict.word_count, word_count_i);
            fails++;
          end
          if (store_full_i !== verdict.store_full) begin
            $error("store_full: expected %0d, actual %0d", verdict.store_full, store_full_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        judge_candidate(cmd_i, candidate_i, verdict);
        pending_verdicts = {pending_verdicts, verdict};
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_VECTOR_LENGTH: vec_len_q  = cfg_data_i;
          REG_MIN_DISTANCE:  min_dist_q = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o  <= fails;
      outstanding_o <= pending_verdicts.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the greedy hamming code builder: directed beats on
// the register extremes and special cases, a full-store fill, then random and
// lexicode-sweep phases under several idling patterns
// ----------------------------------------------------------------------------

module tb;

  import gcb_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;  // far above the slowest correct run
  localparam int DRAIN_CYCLES = 1100;        // a little over one full scan
  localparam int RANDOM_BEATS = 580;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   cmd_i;
  logic [VECTOR_BITS-1:0] candidate_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   accepted_o;
  logic [WC_W-1:0]        word_count_o;
  logic                   store_full_o;

  int          fail_count;
  int          outstanding;
  int          cycle_count;
  int          random_sent;
  int unsigned sender_pct;
  int unsigned receiver_pct;

  greedy_hamming_code_builder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .candidate_i  (candidate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o),
    .word_count_o (word_count_o),
    .store_full_o (store_full_o)
  );

  gcb_checker u_gcb_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .cmd_i         (cmd_i),
    .candidate_i   (candidate_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accepted_i    (accepted_o),
    .word_count_i  (word_count_o),
    .store_full_i  (store_full_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side: stall at random while the current pattern asks for it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_pct);
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("greedy_hamming_code_builder: mismatch");
      $finish;
    end
  end

  // idling patterns: none, sender idle, receiver stalling, both lightly
  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin sender_pct = 0;  receiver_pct = 0;  end
      1: begin sender_pct = 87; receiver_pct = 0;  end
      2: begin sender_pct = 0;  receiver_pct = 87; end
      default: begin sender_pct = 12; receiver_pct = 12; end
    endcase
  endtask

  // one candidate beat; valid stays high after acceptance unless a gap follows
  task automatic send_beat(input logic cmd, input logic [VECTOR_BITS-1:0] cand);
    while ($urandom_range(99) < sender_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    candidate_i <= cand;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sender holds off until every verdict has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // both registers, only ever written with the block idle
  task automatic set_config(input logic [CFG_W-1:0] vlen, input logic [CFG_W-1:0] mdist);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_VECTOR_LENGTH;
    cfg_data_i  <= vlen;
    @(posedge clk_i);
    cfg_index_i <= REG_MIN_DISTANCE;
    cfg_data_i  <= mdist;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned      len;
    logic [CFG_W-1:0] vlen;
    logic [CFG_W-1:0] mdist;
    int               phase;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_TEST;
    candidate_i <= '0;
    cycle_count = 0;
    random_sent = 0;
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: length 8, distance 3, upper bits ignored
    send_beat(CMD_CLEAR, 16'h0000);
    send_beat(CMD_TEST, 16'h0000);
    send_beat(CMD_TEST, 16'hFFFF);
    send_beat(CMD_TEST, 16'h0007);
    send_beat(CMD_TEST, 16'h0001);
    send_beat(CMD_TEST, 16'hFF00);
    send_beat(CMD_TEST, 16'h5A5A);
    wait_idle();

    // zero length treated as one, zero distance held at one
    set_config(5'd0, 5'd0);
    send_beat(CMD_CLEAR, 16'hFFFF);
    send_beat(CMD_TEST, 16'h0000);
    send_beat(CMD_TEST, 16'h0001);
    send_beat(CMD_TEST, 16'hFFFE);
    send_beat(CMD_TEST, 16'h0003);
    wait_idle();

    // length saturated, distance beyond any reachable one
    set_config(5'd31, 5'd31);
    send_beat(CMD_CLEAR, 16'h0000);
    send_beat(CMD_TEST, 16'hFFFF);
    send_beat(CMD_TEST, 16'h0000);
    send_beat(CMD_TEST, 16'h1234);
    wait_idle();

    // full-width extremes
    set_config(5'd16, 5'd16);
    send_beat(CMD_CLEAR, 16'h0000);
    send_beat(CMD_TEST, 16'h0000);
    send_beat(CMD_TEST, 16'hFFFF);
    send_beat(CMD_TEST, 16'h00FF);
    wait_idle();

    // distance above length: only the first word gets in
    set_config(5'd4, 5'd5);
    send_beat(CMD_CLEAR, 16'h0000);
    send_beat(CMD_TEST, 16'h0005);
    send_beat(CMD_TEST, 16'h000A);
    wait_idle();

    // fill the store with distinct words, then knock on a full store
    set_config(5'd16, 5'd1);
    send_beat(CMD_CLEAR, 16'h0000);
    for (int i = 0; i < MAX_WORDS; i++) send_beat(CMD_TEST, VECTOR_BITS'(i));
    send_beat(CMD_TEST, 16'hFFFF);
    send_beat(CMD_TEST, 16'h0005);
    send_beat(CMD_CLEAR, 16'h0000);
    wait_idle();

    // random phases, every third one an ascending lexicode sweep
    phase = 0;
    while (random_sent < RANDOM_BEATS) begin
      set_idling(phase);
      if (phase % 3 == 2) begin
        len   = $urandom_range(3, 7);
        vlen  = CFG_W'(len);
        mdist = CFG_W'($urandom_range(1, 4));
        set_config(vlen, mdist);
        send_beat(CMD_CLEAR, VECTOR_BITS'($urandom));
        random_sent++;
        // noise above the compared bits must not disturb the sweep
        for (int v = 0; v < (1 << len); v++) begin
          send_beat(CMD_TEST, VECTOR_BITS'(v | ($urandom << len)));
          random_sent++;
        end
      end else begin
        case ($urandom_range(5))
          0: vlen = 5'd0;
          1: vlen = 5'd1;
          2: vlen = 5'd16;
          3: vlen = 5'd31;
          default: vlen = CFG_W'($urandom_range(2, 15));
        endcase
        case ($urandom_range(5))
          0: mdist = 5'd0;
          1: mdist = 5'd1;
          2: mdist = 5'd16;
          3: mdist = 5'd31;
          default: mdist = CFG_W'($urandom_range(2, 5));
        endcase
        set_config(vlen, mdist);
        for (int k = 0; k < 60; k++) begin
          if ($urandom_range(49) == 0) wait_idle();
          if ($urandom_range(19) == 0) send_beat(CMD_CLEAR, VECTOR_BITS'($urandom));
          else send_beat(CMD_TEST, VECTOR_BITS'($urandom));
          random_sent++;
        end
      end
      wait_idle();
      phase++;
    end

    // drain and let any late beat show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("greedy_hamming_code_builder: match");
    end else begin
      $display("greedy_hamming_code_builder: mismatch");
    end
    $finish;
  end

endmodule
